[sv/bcc_pkg.sv]
package bcc_pkg;

    // Sideband that travels beside each quotient through the divider
    typedef struct packed {
        logic neg;    // quotient takes a negative sign
        logic degen;  // determinant was zero
    } t_bcc_side;

endpackage

[sv/bcc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// o_q = floor(i_x / i_y), taken from the last stage.
module bcc_div
    import bcc_pkg::*;
#(
    parameter int MW = 26,
    parameter int FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [MW+FB+1:0]     i_x,
    input  logic [MW:0]          i_y,
    input  t_bcc_side            i_side,
    output logic [MW+FB+1:0]     o_q,
    output t_bcc_side            o_side
);

    localparam int XW = MW + FB + 2;

    logic [MW:0]    r_rem  [XW];
    logic [XW-1:0]  r_xq   [XW];
    logic [MW:0]    r_y    [XW];
    t_bcc_side      r_side [XW];

    for (genvar k = 0; k < XW; k++) begin : g_stage
        logic [MW:0]    s_rem;
        logic [XW-1:0]  s_xq;
        logic [MW:0]    s_y;
        t_bcc_side      s_side;
        logic [MW+1:0]  w_part;
        logic [MW+1:0]  w_diff;
        logic           w_ge;
        logic [MW:0]    n_rem;

        // previous stage, or the entry word
        if (k == 0) begin : g_first
            assign s_rem  = '0;
            assign s_xq   = i_x;
            assign s_y    = i_y;
            assign s_side = i_side;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_xq   = r_xq[k-1];
            assign s_y    = r_y[k-1];
            assign s_side = r_side[k-1];
        end

        // bring down one dividend bit, trial subtract
        assign w_part = {s_rem, s_xq[XW-1]};
        assign w_diff = w_part - {1'b0, s_y};
        assign w_ge   = (w_part >= {1'b0, s_y});
        assign n_rem  = w_ge ? w_diff[MW:0] : w_part[MW:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_xq[k]   <= {s_xq[XW-2:0], w_ge};
                r_y[k]    <= s_y;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_q    = r_xq[XW-1];
    assign o_side = r_side[XW-1];

endmodule

[sv/barycentric_coordinates_top.sv]
// Barycentric weights of a query point against a screen-space triangle.
// Input stream (s_axis): one word per query, eight signed coordinates of
// COORD_BITS each: A.x, A.y, B.x, B.y, C.x, C.y, P.x, P.y, lowest first.
// Output stream (m_axis): tdata holds weight_u, weight_v, weight_w, each
// signed fixed point with FRAC_BITS fraction bits, saturated to +/-8;
// tuser is the degenerate flag (zero determinant, weights then zero).
// Pipeline: four setup stages (differences, products, cross terms,
// sign/magnitude), one stage per quotient bit in two parallel long
// dividers, then a sign stage and a saturating output register.
// Throughput: one word per cycle while the pipeline is not held by a stall; every stage holds a valid bit.
// Reset clears all valid bits; no output word follows reset until a new
// input word enters.
// When the receiver stalls with a word waiting at the output, the whole
// pipeline holds and s_axis tready drops; nothing is lost or repeated.
// Empty slots never block: tready stays high while the output is empty.
module barycentric_coordinates_top
    import bcc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
    // vertex_c_x, vertex_c_y, point_x, point_y
    input  logic [8*COORD_BITS-1:0]    i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // weight_u, weight_v, weight_w, zero fill
    output logic [((3*(FRAC_BITS+4)+7)/8)*8-1:0] o_m_axis_tdata,
    // degenerate
    output logic                       o_m_axis_tuser
);

    localparam int C     = COORD_BITS;
    localparam int DW    = C + 1;          // coordinate difference
    localparam int PW    = 2 * DW;         // product
    localparam int CW    = PW + 1;         // cross term
    localparam int MW    = CW - 1;         // cross term magnitude
    localparam int XW    = MW + FRAC_BITS + 2;
    localparam int UW    = XW + 3;
    localparam int OW    = FRAC_BITS + 4;
    localparam int OUT_W = ((3 * OW + 7) / 8) * 8;
    localparam int NS    = XW + 6;         // valid stages

    localparam logic [UW-1:0] ONE = {{(UW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic          w_en;
    logic [NS-1:0] r_vld;

    assign w_en            = !r_vld[NS-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[NS-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_s_axis_tvalid};
        end
    end

    // input fields
    logic [C-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy, w_px, w_py;
    assign w_ax = i_s_axis_tdata[0*C +: C];
    assign w_ay = i_s_axis_tdata[1*C +: C];
    assign w_bx = i_s_axis_tdata[2*C +: C];
    assign w_by = i_s_axis_tdata[3*C +: C];
    assign w_cx = i_s_axis_tdata[4*C +: C];
    assign w_cy = i_s_axis_tdata[5*C +: C];
    assign w_px = i_s_axis_tdata[6*C +: C];
    assign w_py = i_s_axis_tdata[7*C +: C];

    // stage 1: edge vectors relative to A
    logic signed [DW-1:0] r_e0x, r_e0y, r_e1x, r_e1y, r_qx, r_qy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e0x <= $signed({w_bx[C-1], w_bx}) - $signed({w_ax[C-1], w_ax});
            r_e0y <= $signed({w_by[C-1], w_by}) - $signed({w_ay[C-1], w_ay});
            r_e1x <= $signed({w_cx[C-1], w_cx}) - $signed({w_ax[C-1], w_ax});
            r_e1y <= $signed({w_cy[C-1], w_cy}) - $signed({w_ay[C-1], w_ay});
            r_qx  <= $signed({w_px[C-1], w_px}) - $signed({w_ax[C-1], w_ax});
            r_qy  <= $signed({w_py[C-1], w_py}) - $signed({w_ay[C-1], w_ay});
        end
    end

    // stage 2: six products
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0 <= r_e0x * r_e1y;
            r_p1 <= r_e0y * r_e1x;
            r_p2 <= r_qx * r_e1y;
            r_p3 <= r_qy * r_e1x;
            r_p4 <= r_e0x * r_qy;
            r_p5 <= r_e0y * r_qx;
        end
    end

    // stage 3: cross terms
    logic signed [CW-1:0] r_den, r_nv, r_nw;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den <= $signed({r_p0[PW-1], r_p0}) - $signed({r_p1[PW-1], r_p1});
            r_nv  <= $signed({r_p2[PW-1], r_p2}) - $signed({r_p3[PW-1], r_p3});
            r_nw  <= $signed({r_p4[PW-1], r_p4}) - $signed({r_p5[PW-1], r_p5});
        end
    end

    // stage 4: make the divisor positive, split numerators into sign/magnitude
    logic              w_dneg;
    logic [CW-1:0]     w_nvs, w_nws, w_avf, w_awf, w_adf;
    logic [MW-1:0]     w_av, w_aw, w_ad;
    always_comb begin
        w_dneg = r_den[CW-1];
        w_nvs  = w_dneg ? (CW'(0) - r_nv) : r_nv;
        w_nws  = w_dneg ? (CW'(0) - r_nw) : r_nw;
        w_avf  = w_nvs[CW-1] ? (CW'(0) - w_nvs) : w_nvs;
        w_awf  = w_nws[CW-1] ? (CW'(0) - w_nws) : w_nws;
        w_adf  = w_dneg ? (CW'(0) - r_den) : r_den;
        w_av   = w_avf[MW-1:0];
        w_aw   = w_awf[MW-1:0];
        w_ad   = w_adf[MW-1:0];
    end

    logic [XW-1:0] r_xv, r_xw;
    logic [MW:0]   r_y;
    t_bcc_side     r_sv, r_sw;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // round to nearest: (a*2^(F+1) + d) / (2d)
            r_xv      <= {1'b0, w_av, {(FRAC_BITS+1){1'b0}}} + XW'(w_ad);
            r_xw      <= {1'b0, w_aw, {(FRAC_BITS+1){1'b0}}} + XW'(w_ad);
            r_y       <= {w_ad, 1'b0};
            r_sv.neg   <= w_nvs[CW-1];
            r_sv.degen <= (r_den == '0);
            r_sw.neg   <= w_nws[CW-1];
            r_sw.degen <= (r_den == '0);
        end
    end

    // long dividers
    logic [XW-1:0] w_qv, w_qw;
    t_bcc_side     w_sv, w_sw;

    bcc_div #(.MW(MW), .FB(FRAC_BITS)) u_div_v (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_xv),
        .i_y    (r_y),
        .i_side (r_sv),
        .o_q    (w_qv),
        .o_side (w_sv)
    );

    bcc_div #(.MW(MW), .FB(FRAC_BITS)) u_div_w (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_xw),
        .i_y    (r_y),
        .i_side (r_sw),
        .o_q    (w_qw),
        .o_side (w_sw)
    );

    // sign stage
    logic [XW:0] r_v, r_w;
    logic        r_dg;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v  <= w_sv.neg ? ((XW+1)'(0) - {1'b0, w_qv}) : {1'b0, w_qv};
            r_w  <= w_sw.neg ? ((XW+1)'(0) - {1'b0, w_qw}) : {1'b0, w_qw};
            r_dg <= w_sv.degen || w_sw.degen;
        end
    end

    // saturate to OW signed bits
    function automatic logic [OW-1:0] f_sat(input logic [UW-1:0] x);
        logic [UW-OW:0] top;
        top = x[UW-1:OW-1];
        if ((&top) || !(|top)) begin
            return x[OW-1:0];
        end else if (x[UW-1]) begin
            return {1'b1, {(OW-1){1'b0}}};
        end else begin
            return {1'b0, {(OW-1){1'b1}}};
        end
    endfunction

    // output stage: u = 1 - v - w, saturate, zero on degenerate
    logic [UW-1:0] w_ve, w_we, w_u;
    assign w_ve = {{2{r_v[XW]}}, r_v};
    assign w_we = {{2{r_w[XW]}}, r_w};
    assign w_u  = ONE - w_ve - w_we;

    logic [OW-1:0] r_wu, r_wv, r_ww;
    logic          r_dgo;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wu  <= r_dg ? '0 : f_sat(w_u);
            r_wv  <= r_dg ? '0 : f_sat(w_ve);
            r_ww  <= r_dg ? '0 : f_sat(w_we);
            r_dgo <= r_dg;
        end
    end

    assign o_m_axis_tdata = OUT_W'({r_ww, r_wv, r_wu});
    assign o_m_axis_tuser = r_dgo;

endmodule
